### src/pip_pkg.sv
package pip_pkg;

	// Request kinds carried in s_tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Fixed field widths of the stream and configuration ports
	localparam int IDX_W = 6;
	localparam int CFG_W = 7;

	// Fewer vertices than this never enclose a point
	localparam int MIN_VERTS = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} pip_state_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_en;   // write load item into vertex store
		logic cap;     // latch query point, clear parity
		logic rd_en;   // read one vertex
		logic edge_en; // the read vertex closes an edge with the previous one
	} pip_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic busy;    // edge pipeline still holds work
	} pip_stat_t;

endpackage

### src/point_in_polygon_test.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: vertex_index, x_coord, y_coord
// cfg_*     in   cfg_valid/cfg_ready cfg_data: vertex_count
// m_*       out  m_tvalid/m_tready  tdata: inside_res
//
// A load is written to the store as it is accepted. A query with n vertices in use
// (clamped to MAX_VERTICES) walks one edge per cycle through a single store read port:
// the accept, reads of vertex 0 and then vertices 1 to n - 1 and vertex 0 again for
// the closing edge, a pipeline drain whose length depends on whether the last edges
// straddle the query y, then the result is held until m_tready is high.
// A query with fewer than three vertices skips the walk and goes to the result.
// Reset is asynchronous, active low; the vertex store is not cleared.
// While a result waits on m_tready no new item is accepted.
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// [0] req_type
	input  logic                                          s_tuser,
	// [5:0] vertex_index, then x_coord, then y_coord, zero padding on top
	input  logic [((IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [CFG_W-1:0]                              cfg_data,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// [0] inside_res, zero padding above
	output logic [7:0]                                    m_tdata
);

	localparam int AW = $clog2(MAX_VERTICES);

	pip_cmd_t               cmd;
	pip_stat_t              stat;
	logic [AW-1:0]          rd_addr, wr_addr;
	logic                   inside_res;
	logic [IDX_W-1:0]       vertex_index;
	logic [COORD_WIDTH-1:0] x_coord, y_coord;

	// Unpack the input item
	assign vertex_index = s_tdata[IDX_W-1:0];
	assign x_coord      = s_tdata[IDX_W +: COORD_WIDTH];
	assign y_coord      = s_tdata[IDX_W + COORD_WIDTH +: COORD_WIDTH];

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.vertex_index (vertex_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.stat         (stat),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.x_in       (x_coord),
		.y_in       (y_coord),
		.stat       (stat),
		.inside_res (inside_res)
	);

	assign m_tdata = {7'b0, inside_res};

endmodule

### src/pip_datapath.sv
module pip_datapath
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pip_cmd_t                        cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
	input  logic [COORD_WIDTH-1:0]          x_in,
	input  logic [COORD_WIDTH-1:0]          y_in,
	output pip_stat_t                       stat,
	output logic                            inside_res
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	// Vertex store
	logic [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
	logic [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

	logic [COORD_WIDTH-1:0] rd_x_s1, rd_y_s1;
	logic                   rd_v_s1, edge_s1;

	logic [COORD_WIDTH-1:0] qx_q, qy_q;
	logic [COORD_WIDTH-1:0] prev_x_q, prev_y_q;

	logic signed [DW-1:0] a_s2, b_s2, c_s2, d_s2;
	logic                 v_s2, up_s2;

	logic signed [PW-1:0] p1_s3, p2_s3;
	logic                 v_s3, up_s3;

	logic parity_q;

	logic signed [DW-1:0] xi, yi, xj, yj, qx, qy;
	logic                 bi, bj;

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_x[wr_addr] <= x_in;
			mem_y[wr_addr] <= y_in;
		end
		if (cmd.rd_en) begin
			rd_x_s1 <= mem_x[rd_addr];
			rd_y_s1 <= mem_y[rd_addr];
		end
	end

	// Sign-extended operands of the current edge
	always_comb begin
		xi = DW'($signed(prev_x_q));
		yi = DW'($signed(prev_y_q));
		xj = DW'($signed(rd_x_s1));
		yj = DW'($signed(rd_y_s1));
		qx = DW'($signed(qx_q));
		qy = DW'($signed(qy_q));
		bi = yi < qy;
		bj = yj < qy;
	end

	// Payload: query point, previous vertex, differences, products
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			qx_q <= x_in;
			qy_q <= y_in;
		end
		if (rd_v_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
		a_s2  <= qy - yi;
		b_s2  <= xj - xi;
		c_s2  <= qx - xi;
		d_s2  <= yj - yi;
		up_s2 <= bi;
		p1_s3 <= PW'(a_s2) * PW'(b_s2);
		p2_s3 <= PW'(c_s2) * PW'(d_s2);
		up_s3 <= up_s2;
	end

	// Pipeline valid bits and crossing parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			edge_s1  <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
			edge_s1 <= cmd.edge_en;
			// only edges that straddle the query y go on
			v_s2    <= rd_v_s1 && edge_s1 && (bi != bj);
			v_s3    <= v_s2;
			if (cmd.cap) begin
				parity_q <= 1'b0;
			end else if (v_s3) begin
				// crossing left of the point; compare flips for a downward edge
				if (up_s3 ? (p1_s3 < p2_s3) : (p2_s3 < p1_s3)) begin
					parity_q <= ~parity_q;
				end
			end
		end
	end

	assign stat.busy  = rd_v_s1 || v_s2 || v_s3;
	assign inside_res = parity_q;

endmodule

### src/pip_ctrl.sv
module pip_ctrl
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,
	input  logic [IDX_W-1:0]                vertex_index,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_W-1:0]                cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  pip_stat_t                       stat,
	output pip_cmd_t                        cmd,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0] wr_addr
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	pip_state_t         state_q, state_d;
	logic [CFG_W-1:0]   vertex_count_q;
	logic [CNT_W-1:0]   k_q, k_d;
	logic [CNT_W-1:0]   n;
	logic               slot_ok;

	// Vertex count clamped to the store depth
	always_comb begin
		if (32'(vertex_count_q) > MAX_VERTICES) begin
			n = CNT_W'(MAX_VERTICES);
		end else begin
			n = CNT_W'(vertex_count_q);
		end
	end

	assign slot_ok   = 32'(vertex_index) < MAX_VERTICES;
	assign wr_addr   = AW'(vertex_index);
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid) begin
			vertex_count_q <= cfg_data;
		end
	end

	// State and edge counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		cmd         = '0;
		rd_addr     = '0;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == REQ_LOAD) begin
						cmd.wr_en = slot_ok;
					end else begin
						cmd.cap = 1'b1;
						state_d = (32'(n) < MIN_VERTS) ? ST_RESULT : ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				// vertex 0 primes the previous-vertex register
				cmd.rd_en = 1'b1;
				k_d       = CNT_W'(1);
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				cmd.rd_en   = 1'b1;
				cmd.edge_en = 1'b1;
				if (k_q == n) begin
					// closing edge back to vertex 0
					state_d = ST_DRAIN;
				end else begin
					rd_addr = k_q[AW-1:0];
					k_d     = k_q + CNT_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Never take an item while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	// Reads stay inside the polygon in use
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CNT_W'(rd_addr) < n))
		else $error("vertex read beyond count");

	// Result only shown after the edge pipeline has emptied
	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> !stat.busy)
		else $error("result shown with edges in flight");

	// The walk ends only at the closing edge
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && state_d == ST_DRAIN) |-> (k_q == n))
		else $error("walk left early");

endmodule

### verif/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps

module tb_point_in_polygon_test;
	import pip_pkg::*;

	localparam int COORD_W      = 32;
	localparam int STORE_DEPTH  = 64;
	localparam int S_W          = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
	localparam int UNIT         = 256;
	localparam int ITEM_GOAL    = 400;
	localparam int QUIET_FROM   = 340;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 300000;

	// how vertex and query coordinates are spread
	typedef enum int {
		COORD_GRID,
		COORD_WIDE,
		COORD_FULL
	} coord_spread_t;

	// Tracks the vertex store and vertex count, predicts inside_res per query
	class polygon_tracker;
		logic signed [COORD_W-1:0] vx [STORE_DEPTH];
		logic signed [COORD_W-1:0] vy [STORE_DEPTH];
		int unsigned vcount;
		bit inside_due[$];
		int mismatches;
		int results_seen;

		function new();
			vcount = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_count(logic [CFG_W-1:0] value);
			vcount = 32'(value);
		endfunction

		function int pending();
			return inside_due.size();
		endfunction

		// even-odd crossing count, exact via cross products
		function bit crossing_parity(logic signed [COORD_W-1:0] qx,
			logic signed [COORD_W-1:0] qy);
			int unsigned n;
			int nxt;
			bit odd;
			bit below_a;
			bit below_b;
			logic signed [COORD_W:0] ly, lx, rx, ry;
			logic signed [2*COORD_W+1:0] lhs, rhs;
			n = (vcount > STORE_DEPTH) ? STORE_DEPTH : vcount;
			odd = 1'b0;
			if (n < MIN_VERTS)
				return 1'b0;
			for (int k = 0; k < n; k++) begin
				nxt = (k + 1 == n) ? 0 : k + 1;
				below_a = vy[k] < qy;
				below_b = vy[nxt] < qy;
				if (below_a != below_b) begin
					ly = {qy[COORD_W-1], qy} - {vy[k][COORD_W-1], vy[k]};
					lx = {vx[nxt][COORD_W-1], vx[nxt]} - {vx[k][COORD_W-1], vx[k]};
					rx = {qx[COORD_W-1], qx} - {vx[k][COORD_W-1], vx[k]};
					ry = {vy[nxt][COORD_W-1], vy[nxt]} - {vy[k][COORD_W-1], vy[k]};
					lhs = ly * lx;
					rhs = rx * ry;
					// comparison flips for a downward edge
					if (below_a ? (lhs < rhs) : (rhs < lhs))
						odd = ~odd;
				end
			end
			return odd;
		endfunction

		function void take_item(logic kind, logic [IDX_W-1:0] slot,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
			if (kind == REQ_LOAD) begin
				vx[slot] = x;
				vy[slot] = y;
			end else begin
				inside_due.push_back(crossing_parity(x, y));
			end
		endfunction

		function void check_inside(logic [7:0] word);
			bit want;
			results_seen++;
			if (inside_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: no query outstanding, inside_res=%0d",
						results_seen, word[0]);
				return;
			end
			want = inside_due.pop_front();
			if (word[0] !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: inside_res expected %0d actual %0d",
						results_seen, want, word[0]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic s_tuser = REQ_LOAD;
	logic [S_W-1:0] s_tdata = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;

	polygon_tracker tracker;
	bit idle_on = 1'b1;
	int items_sent = 0;
	int ready_hold = 0;
	int cycles = 0;

	point_in_polygon_test u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall bursts on m_tready while idling is on
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_inside(m_tdata);
	end

	function automatic logic [COORD_W-1:0] pick_coord(coord_spread_t spread);
		int v;
		case (spread)
			COORD_GRID: begin
				v = (int'($urandom_range(0, 20)) - 10) * UNIT;
				if ($urandom_range(0, 3) == 0)
					v += int'($urandom_range(0, UNIT - 1));
			end
			COORD_WIDE: v = int'($urandom) >>> 11;
			default: begin
				case ($urandom_range(0, 7))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 0;
					3: v = -1;
					default: v = int'($urandom);
				endcase
			end
		endcase
		return v;
	endfunction

	// one item on the request stream; valid stays high into the next call
	task automatic send_item(logic kind, logic [IDX_W-1:0] slot,
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= S_W'({y, x, slot});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_item(kind, slot, x, y);
		items_sent++;
		if (items_sent >= QUIET_FROM)
			idle_on = 1'b0;
	endtask

	task automatic query_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		send_item(REQ_QUERY, IDX_W'($urandom_range(0, STORE_DEPTH - 1)), x, y);
	endtask

	// vertex_count write, only once the block has gone quiet
	task automatic write_count(logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_count(value);
		cfg_valid <= 1'b0;
	endtask

	// new count, full polygon load if it has MIN_VERTS or more, then queries with the odd vertex rewrite
	task automatic run_polygon(logic [CFG_W-1:0] count);
		int n;
		int rot;
		int nq;
		coord_spread_t spread;
		coord_spread_t qspread;
		case ($urandom_range(0, 3))
			0, 1: spread = COORD_GRID;
			2: spread = COORD_WIDE;
			default: spread = COORD_FULL;
		endcase
		write_count(count);
		n = (count > STORE_DEPTH) ? STORE_DEPTH : count;
		rot = $urandom_range(0, STORE_DEPTH - 1);
		if (n >= MIN_VERTS) begin
			for (int k = 0; k < n; k++)
				send_item(REQ_LOAD, IDX_W'((rot + k) % n), pick_coord(spread),
					pick_coord(spread));
		end
		nq = $urandom_range(4, 12);
		for (int q = 0; q < nq; q++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(REQ_LOAD, IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
					pick_coord(spread), pick_coord(spread));
			end else begin
				qspread = ($urandom_range(0, 7) == 0) ? COORD_FULL : spread;
				query_point(pick_coord(qspread), pick_coord(qspread));
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] count;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// too few vertices: outside without touching the store
		write_count(CFG_W'(0));
		query_point(0, 0);
		write_count(CFG_W'(2));
		query_point(UNIT, UNIT);

		// square, queries inside, outside, on edges and on tie rows
		write_count(CFG_W'(4));
		send_item(REQ_LOAD, IDX_W'(0), -100 * UNIT, -100 * UNIT);
		send_item(REQ_LOAD, IDX_W'(1), 100 * UNIT, -100 * UNIT);
		send_item(REQ_LOAD, IDX_W'(2), 100 * UNIT, 100 * UNIT);
		send_item(REQ_LOAD, IDX_W'(3), -100 * UNIT, 100 * UNIT);
		query_point(0, 0);
		query_point(200 * UNIT, 0);
		query_point(0, 100 * UNIT);
		query_point(-100 * UNIT, 0);
		query_point(100 * UNIT, 50 * UNIT);
		query_point(0, -100 * UNIT);

		// triangle at the coordinate extremes, products past 64 bits
		write_count(CFG_W'(3));
		send_item(REQ_LOAD, IDX_W'(0), 32'h8000_0000, 32'h8000_0000);
		send_item(REQ_LOAD, IDX_W'(1), 32'h7fff_ffff, 32'h8000_0000);
		send_item(REQ_LOAD, IDX_W'(2), 0, 32'h7fff_ffff);
		send_item(REQ_LOAD, IDX_W'(63), 32'h7fff_ffff, 32'h8000_0000);
		query_point(0, 0);
		query_point(32'h8000_0000, 32'h8000_0000);
		query_point(32'h7fff_ffff, 32'h7fff_ffff);
		query_point(32'hffff_ffff, 32'h7fff_0000);

		// count above the store size saturates
		run_polygon(CFG_W'(127));
		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 15))
				0: count = CFG_W'($urandom_range(0, MIN_VERTS - 1));
				1: count = CFG_W'(STORE_DEPTH);
				2: count = CFG_W'($urandom_range(STORE_DEPTH + 1, 127));
				default: count = CFG_W'($urandom_range(MIN_VERTS, 12));
			endcase
			run_polygon(count);
		end

		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
